@@ sv/assert_macros.svh @@
// Assertion macros shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/pbenc_pkg.sv @@
// Types, constants and codes shared by the run-length encoder modules.
package pbenc_pkg;

	localparam int DEF_MAX_PACKET = 128;

	// Header base for run packets and the end-of-stream marker
	localparam logic [8:0] RUN_BASE = 9'd257;
	localparam logic [7:0] END_MARK = 8'd128;

	// Input item kind code
	localparam logic KIND_FINISH = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] out_bytes;
		logic [2:0]  byte_count;
		logic        last;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic commit;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic needs_drain;
		logic drain_done;
	} ctl_sts_t;

endpackage

@@ sv/pbenc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pbenc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = pbenc_pkg::DEF_MAX_PACKET
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port and registered read port (read returns old data on a clash)
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/pbenc_ctl.sv @@
// Controller state machine: takes items and waits out each packet drain.
`include "assert_macros.svh"

module pbenc_ctl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pbenc_pkg::ctl_sts_t sts,
	output pbenc_pkg::ctl_cmd_t cmd
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic state_q;
	logic state_d;

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.accept = in_valid && in_ready;
	assign cmd.commit = (state_q == ST_DRAIN) && sts.drain_done;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept && sts.needs_drain) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (sts.drain_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The byte sequencer must be empty whenever a new item may be taken
	`PB_ASSERT_IMP(a_idle_drained, clk, arst_n, state_q == ST_IDLE, sts.drain_done,
		"controller idle while the datapath still drains")

endmodule

@@ sv/pbenc_dp.sv @@
// Datapath: encoder state, packet store, byte sequencer and word packer.
`include "assert_macros.svh"

module pbenc_dp #(
	parameter int MAX_PACKET = pbenc_pkg::DEF_MAX_PACKET
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pbenc_pkg::in_item_t  in_data,
	input  pbenc_pkg::ctl_cmd_t  cmd,
	output pbenc_pkg::ctl_sts_t  sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pbenc_pkg::out_item_t out_data
);

	localparam int CW = $clog2(MAX_PACKET + 1);
	localparam int AW = $clog2(MAX_PACKET);
	localparam int LW = $clog2(MAX_PACKET + 3);

	localparam logic [8:0] RUN_BASE_W = pbenc_pkg::RUN_BASE;

	// Encoder state
	logic [CW-1:0] fill_q;
	logic [7:0]    last_q;
	logic          run_q;

	// Packet being drained
	logic [CW-1:0] pkt_n_q;
	logic          pkt_run_q;
	logic [7:0]    run_byte_q;
	logic [LW-1:0] len_q;
	logic          wr_pend_q;
	logic [7:0]    wr_byte_q;

	// Sequencer stage and output stage
	logic [LW-1:0] pos_q;
	logic          busy_q;
	logic          vld_s2;
	logic [LW-1:0] pos_s2;
	logic          last_s2;
	logic [23:0]   acc_q;
	logic [1:0]    cnt_q;
	logic          out_valid_q;
	pbenc_pkg::out_item_t out_q;

	// Decision signals
	logic [7:0]    c;
	logic          fin;
	logic          same;
	logic          full;
	logic [CW-1:0] nxt_fill;
	logic [7:0]    nxt_last;
	logic          nxt_run;
	logic [CW-1:0] em_n;
	logic          em_run;
	logic          em_term;
	logic [LW-1:0] pk_len;
	logic [LW-1:0] em_len;
	logic          wr_now;
	logic [AW-1:0] wr_now_addr;
	logic          wr_later;

	// Store port signals
	logic          ram_wr_en;
	logic [AW-1:0] ram_wr_addr;
	logic [7:0]    ram_wr_data;
	logic          ram_rd_en;
	logic [LW-1:0] pos_m1;
	logic [7:0]    ram_rd_data;

	// Sequencer and packer signals
	logic          adv;
	logic [LW-1:0] len_m1;
	logic          has_pkt;
	logic [8:0]    hdr_run;
	logic [7:0]    hdr;
	logic [7:0]    byte_s2;
	logic [31:0]   wrd;
	logic          flush;

	// Decide what the incoming item does to the pending packet
	always_comb begin
		c           = in_data.data_byte;
		fin         = (in_data.kind == pbenc_pkg::KIND_FINISH);
		same        = (last_q == c);
		full        = (fill_q >= CW'(MAX_PACKET));
		nxt_fill    = fill_q;
		nxt_last    = last_q;
		nxt_run     = run_q;
		em_n        = '0;
		em_run      = 1'b0;
		em_term     = 1'b0;
		wr_now      = 1'b0;
		wr_now_addr = fill_q[AW-1:0];
		wr_later    = 1'b0;
		if (fin) begin
			em_n     = fill_q;
			em_run   = run_q;
			em_term  = 1'b1;
			nxt_fill = '0;
			nxt_last = '0;
			nxt_run  = 1'b0;
		end else if (fill_q == '0) begin
			wr_now      = 1'b1;
			wr_now_addr = '0;
			nxt_fill    = CW'(1);
			nxt_last    = c;
			nxt_run     = 1'b0;
		end else if (full) begin
			em_n     = fill_q;
			em_run   = run_q;
			wr_later = 1'b1;
			nxt_fill = CW'(1);
			nxt_last = c;
			nxt_run  = 1'b0;
		end else if (same && (run_q || fill_q == CW'(1))) begin
			wr_now   = 1'b1;
			nxt_fill = fill_q + CW'(1);
			nxt_last = c;
			nxt_run  = 1'b1;
		end else if (!run_q) begin
			if (same) begin
				// literal closes one byte short, two-byte run starts
				em_n     = fill_q - CW'(1);
				nxt_fill = CW'(2);
				nxt_last = c;
				nxt_run  = 1'b1;
			end else begin
				wr_now   = 1'b1;
				nxt_fill = fill_q + CW'(1);
				nxt_last = c;
			end
		end else begin
			// run broken
			em_n     = fill_q;
			em_run   = 1'b1;
			wr_later = 1'b1;
			nxt_fill = CW'(1);
			nxt_last = c;
			nxt_run  = 1'b0;
		end
		if (em_n == '0) begin
			pk_len = '0;
		end else if (em_run) begin
			pk_len = LW'(2);
		end else begin
			pk_len = LW'(em_n) + LW'(1);
		end
		em_len = pk_len + LW'(em_term);
	end

	assign sts.needs_drain = em_term || (em_n != '0);
	assign sts.drain_done  = !busy_q && !vld_s2;

	// Encoder state and packet capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			last_q    <= '0;
			run_q     <= 1'b0;
			wr_pend_q <= 1'b0;
		end else if (cmd.accept) begin
			fill_q    <= nxt_fill;
			last_q    <= nxt_last;
			run_q     <= nxt_run;
			wr_pend_q <= wr_later;
		end else if (cmd.commit) begin
			wr_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pkt_n_q    <= em_n;
			pkt_run_q  <= em_run;
			run_byte_q <= last_q;
			len_q      <= em_len;
			wr_byte_q  <= c;
		end
	end

	// Packet store: appends on accept, deferred first-byte write after a drain
	assign ram_wr_en   = (cmd.accept && wr_now) || (cmd.commit && wr_pend_q);
	assign ram_wr_addr = cmd.commit ? '0 : wr_now_addr;
	assign ram_wr_data = cmd.commit ? wr_byte_q : c;
	assign adv         = !out_valid_q || out_ready;
	assign ram_rd_en   = adv && busy_q;
	assign pos_m1      = pos_q - LW'(1);

	pbenc_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PACKET)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(pos_m1[AW-1:0]),
		.rd_data(ram_rd_data)
	);

	// Byte sequencer: one packet byte position per cycle while the output is not stalled
	assign len_m1 = len_q - LW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (cmd.accept) begin
				busy_q <= sts.needs_drain;
			end else if (adv && busy_q && pos_q == len_m1) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				vld_s2 <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pos_q <= '0;
		end else if (adv && busy_q) begin
			pos_q <= pos_q + LW'(1);
		end
		if (adv && busy_q) begin
			pos_s2  <= pos_q;
			last_s2 <= (pos_q == len_m1);
		end
	end

	// Byte select: header, run byte, stored literal bytes, end marker
	always_comb begin
		has_pkt = (pkt_n_q != '0);
		hdr_run = RUN_BASE_W - 9'(pkt_n_q);
		hdr     = pkt_run_q ? hdr_run[7:0] : 8'(pkt_n_q - CW'(1));
		if (has_pkt && pos_s2 == '0) begin
			byte_s2 = hdr;
		end else if (has_pkt && pkt_run_q && pos_s2 == LW'(1)) begin
			byte_s2 = run_byte_q;
		end else if (has_pkt && !pkt_run_q && pos_s2 <= LW'(pkt_n_q)) begin
			byte_s2 = ram_rd_data;
		end else begin
			byte_s2 = pbenc_pkg::END_MARK;
		end
		wrd   = {8'h00, acc_q} | (32'(byte_s2) << {cnt_q, 3'b000});
		flush = (cnt_q == 2'd3) || last_s2;
	end

	// Word packer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv && vld_s2) begin
				if (flush) begin
					acc_q <= '0;
					cnt_q <= '0;
				end else begin
					acc_q <= wrd[23:0];
					cnt_q <= cnt_q + 2'd1;
				end
			end
			if (adv && vld_s2 && flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s2 && flush) begin
			out_q.out_bytes  <= wrd;
			out_q.byte_count <= 3'(cnt_q) + 3'd1;
			out_q.last       <= last_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`PB_ASSERT_IMP(a_fill_range, clk, arst_n, 1'b1, fill_q <= CW'(MAX_PACKET),
		"pending byte count beyond store depth")
	`PB_ASSERT_IMP(a_pos_bound, clk, arst_n, busy_q, pos_q < len_q,
		"sequencer position past packet length")
	`PB_ASSERT_IMP(a_out_count, clk, arst_n, out_valid_q,
		out_q.byte_count != 3'd0 && out_q.byte_count <= 3'd4,
		"result word with bad byte count")
	`PB_ASSERT_NXT(a_stall_hold, clk, arst_n, busy_q && !adv && !cmd.accept, $stable(pos_q),
		"sequencer moved while the output was stalled")

endmodule

@@ sv/packbits_encoder.sv @@
// Top level of the streaming PackBits run-length encoder.
//
// Input channel in_valid/in_ready/in_data carries one item: a data byte
// (kind 0) or a finish marker (kind 1). Output channel out_valid/out_ready/
// out_data carries result words of up to four packet bytes, first byte in
// bits 7:0, with byte_count and a last flag on the final word of an item.
// An item that closes no packet gives no result word.
// An item that closes a packet of L bytes (header, data, and the end marker
// on finish; L is at most MAX_PACKET + 2) holds in_ready low after
// acceptance until the packet has drained: the packet store has one read
// port and the sequencer moves one byte a cycle while the output is not
// stalled.
// Reset clears the pending count, last byte and run flag and empties the
// sequencer; the packet store itself needs no clearing.
// A stalled receiver holds the output register, which halts the sequencer
// and in turn keeps in_ready low until the drain can finish.
module packbits_encoder #(
	parameter int MAX_PACKET = pbenc_pkg::DEF_MAX_PACKET
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pbenc_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pbenc_pkg::out_item_t out_data
);

	pbenc_pkg::ctl_cmd_t cmd;
	pbenc_pkg::ctl_sts_t sts;

	pbenc_ctl u_ctl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	pbenc_dp #(
		.MAX_PACKET(MAX_PACKET)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
